>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while reset is low
`define EIG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that an expression never holds
`define EIG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> rtl/core/eig_pkg.sv
// ---------------------------------------------------------------------------
// eig_pkg
// types and codes shared by the interval generator core and its checker
// ---------------------------------------------------------------------------
package eig_pkg;

    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned THRESH_W  = 15;
    localparam int unsigned WAIT_W    = 11;
    localparam int unsigned TIME_W    = 24;
    localparam int unsigned CFG_W     = 24;

    // item operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic REG_RUN_LIMIT    = 1'b0;
    localparam logic REG_ENTRIES_USED = 1'b1;

    localparam logic [TIME_W-1:0] RUN_LIMIT_RST    = 24'd60000;
    localparam logic [WAIT_W-1:0] ENTRIES_USED_RST = 11'd1024;

    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  index;
        logic [THRESH_W-1:0] threshold;
        logic [THRESH_W-1:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_res;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] events;
        logic              done_res;
    } t_out_item;

    // requests from the sequencer to the table search unit
    typedef struct packed {
        logic load;
        logic go;
    } t_srch_req;

    // status back from the table search unit
    typedef struct packed {
        logic              done;
        logic [WAIT_W-1:0] wait_val;
    } t_srch_stat;

endpackage

>>> rtl/core/eig_table_search.sv
// ---------------------------------------------------------------------------
// eig_table_search
// threshold table memory with a one-probe-per-cycle binary search unit
// ---------------------------------------------------------------------------
module eig_table_search #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  eig_pkg::t_srch_req              i_req,
    input  logic [eig_pkg::INDEX_W-1:0]     i_wr_index,
    input  logic [eig_pkg::THRESH_W-1:0]    i_wr_thresh,
    input  logic [eig_pkg::THRESH_W-1:0]    i_value,
    input  logic [eig_pkg::WAIT_W-1:0]      i_entries,
    output eig_pkg::t_srch_stat             o_stat
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PROBE = 2'b10
    } t_srch_state;

    t_srch_state r_state, n_state;

    logic [eig_pkg::THRESH_W-1:0] r_mem [TABLE_DEPTH];
    logic [eig_pkg::THRESH_W-1:0] r_rd_data;
    logic [AW-1:0]                w_rd_addr;

    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW:0]   w_span_sum;
    logic [CW-1:0] w_limit;
    logic [eig_pkg::THRESH_W-1:0] r_value, n_value;
    logic          r_done, n_done;
    logic [eig_pkg::WAIT_W-1:0] r_wait, n_wait;
    logic          w_wr_en;

    // entries in use, saturated to the table depth
    assign w_limit = (32'(i_entries) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(i_entries);

    // loads beyond the table are dropped
    assign w_wr_en = i_req.load && (32'(i_wr_index) < TABLE_DEPTH);

    // next probe point from the narrowed window
    assign w_span_sum = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_mid      = w_span_sum[CW:1];

    // search sequencer
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_value = r_value;
        n_done  = 1'b0;
        n_wait  = r_wait;
        case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_value = i_value;
                    n_lo    = '0;
                    n_hi    = w_limit;
                    if (w_limit == '0) begin
                        n_done = 1'b1;
                        n_wait = '0;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_rd_data >= r_value) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
                if (n_lo == n_hi) begin
                    n_done  = 1'b1;
                    n_wait  = eig_pkg::WAIT_W'(n_lo);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_rd_addr = AW'(n_mid);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // search window and probe value
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_value <= n_value;
        r_wait  <= n_wait;
    end

    // table memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[AW'(i_wr_index)] <= i_wr_thresh;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_stat.done     = r_done;
    assign o_stat.wait_val = r_wait;

endmodule

>>> rtl/core/exponential_interval_generator_core.sv
// ---------------------------------------------------------------------------
// exponential_interval_generator_core
// poisson inter-arrival generator by inverse-cdf table lookup
// ---------------------------------------------------------------------------
// A load beat (op = load) writes one threshold; busy stays low. A sample beat
// raises busy and binary-searches the table at one memory probe per clock
// over the entries in use (at most TABLE_DEPTH), as the table has a single
// read port. The result beat shows on o_result for exactly one cycle with
// o_res_valid high, in the cycle busy drops; the receiver must take it then,
// as it is never held. Write configuration only while busy is low.
module exponential_interval_generator_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  eig_pkg::t_in_item               i_item,
    output logic                            o_res_valid,
    output eig_pkg::t_out_item              o_result,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [eig_pkg::CFG_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_ctl_state;

    t_ctl_state r_state, n_state;

    logic [eig_pkg::TIME_W-1:0] r_run_limit;
    logic [eig_pkg::WAIT_W-1:0] r_entries;
    logic [eig_pkg::TIME_W-1:0] r_elapsed, n_elapsed;
    logic [eig_pkg::TIME_W-1:0] r_events, n_events;
    logic                       r_res_valid, n_res_valid;
    eig_pkg::t_out_item         r_result, n_result;

    eig_pkg::t_srch_req  w_req;
    eig_pkg::t_srch_stat w_stat;
    logic                w_accept;
    logic [eig_pkg::TIME_W:0]   w_sum;
    logic [eig_pkg::TIME_W-1:0] w_events_inc;
    logic                w_fits;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_req.load = w_accept && (i_item.op == eig_pkg::OP_LOAD);
    assign w_req.go   = w_accept && (i_item.op == eig_pkg::OP_SAMPLE);

    // table and search unit
    eig_table_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_wr_index  (i_item.index),
        .i_wr_thresh (i_item.threshold),
        .i_value     (i_item.random_value),
        .i_entries   (r_entries),
        .o_stat      (w_stat)
    );

    // run limit check on the drawn wait
    assign w_sum        = {1'b0, r_elapsed} + (eig_pkg::TIME_W + 1)'(w_stat.wait_val);
    assign w_fits       = (w_sum <= {1'b0, r_run_limit});
    assign w_events_inc = r_events + eig_pkg::TIME_W'(1);

    // sequencer and run counters
    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_events    = r_events;
        n_res_valid = 1'b0;
        n_result    = r_result;
        case (r_state)
            ST_IDLE: begin
                if (w_req.go) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_stat.done) begin
                    n_state           = ST_IDLE;
                    n_res_valid       = 1'b1;
                    n_result.wait_res = w_stat.wait_val;
                    if (w_fits) begin
                        n_elapsed         = w_sum[eig_pkg::TIME_W-1:0];
                        n_events          = w_events_inc;
                        n_result.elapsed  = w_sum[eig_pkg::TIME_W-1:0];
                        n_result.events   = w_events_inc;
                        n_result.done_res = 1'b0;
                    end else begin
                        n_elapsed         = '0;
                        n_events          = '0;
                        n_result.elapsed  = r_elapsed;
                        n_result.events   = r_events;
                        n_result.done_res = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_elapsed   <= '0;
            r_events    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_events    <= n_events;
            r_res_valid <= n_res_valid;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_limit <= eig_pkg::RUN_LIMIT_RST;
            r_entries   <= eig_pkg::ENTRIES_USED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                eig_pkg::REG_RUN_LIMIT: begin
                    r_run_limit <= i_cfg_data[eig_pkg::TIME_W-1:0];
                end
                eig_pkg::REG_ENTRIES_USED: begin
                    r_entries <= i_cfg_data[eig_pkg::WAIT_W-1:0];
                end
                default: begin
                    r_entries <= r_entries;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

>>> rtl/core/eig_checker.sv
// ---------------------------------------------------------------------------
// eig_checker
// port-level checks of the interval generator core, bound to the core module
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eig_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  eig_pkg::t_in_item               i_item,
    input  logic                            o_res_valid
);

    logic w_load_beat;
    logic w_sample_beat;

    assign w_load_beat   = start && !busy && (i_item.op == eig_pkg::OP_LOAD);
    assign w_sample_beat = start && !busy && (i_item.op == eig_pkg::OP_SAMPLE);

    // a load never occupies the block
    `EIG_ASSERT(a_load_no_busy, i_clk, i_rst_n, w_load_beat |=> !busy, "load made the core busy")

    // a sample always occupies the block
    `EIG_ASSERT(a_sample_busy, i_clk, i_rst_n, w_sample_beat |=> busy, "sample not taken up")

    // result beats come only once the search is over
    `EIG_ASSERT_NEVER(a_res_while_busy, i_clk, i_rst_n, o_res_valid && busy, "result while busy")

    // each result beat lasts a single cycle
    `EIG_ASSERT(a_res_one_cycle, i_clk, i_rst_n, o_res_valid |=> !o_res_valid, "result repeated")

endmodule

bind exponential_interval_generator_core eig_checker u_eig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_item      (i_item),
    .o_res_valid (o_res_valid)
);
